FILE: rtl/core/r5900_instruction_decoder_defines.svh
// Assertion macros used by the decoder top level
`ifndef R5900_INSTRUCTION_DECODER_DEFINES_SVH
`define R5900_INSTRUCTION_DECODER_DEFINES_SVH
// Clocked assertion on i_clk, idle while i_rst_n is low
`define R5K_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Consequent must hold in the cycle after the antecedent
`define R5K_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/core/r5k_dec_pkg.sv
// Package: decode group codes, opcode constants and acceptance masks
package r5k_dec_pkg;
    typedef enum logic [3:0] {
        G_MAIN = 4'd0, G_SPECIAL = 4'd1, G_REGIMM = 4'd2, G_COP0MV = 4'd3,
        G_BC0 = 4'd4, G_TLB = 4'd5, G_COP1MV = 4'd6, G_BC1 = 4'd7,
        G_FPUS = 4'd8, G_FPUW = 4'd9, G_COP2MV = 4'd10, G_BC2 = 4'd11,
        G_VU1 = 4'd12, G_VU2 = 4'd13, G_MMI = 4'd14, G_COP3 = 4'd15
    } t_group;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_COP1    = 6'h11;
    localparam logic [5:0] OP_COP2    = 6'h12;
    localparam logic [5:0] OP_COP3    = 6'h13;
    localparam logic [5:0] OP_MMI     = 6'h1C;

    localparam logic [4:0] FMT_BC  = 5'h08;
    localparam logic [4:0] FMT_CO  = 5'h10;
    localparam logic [4:0] FMT_W   = 5'h14;
    localparam logic [5:0] FN_CVTS = 6'h20;

    localparam logic [63:0] MAIN_OK = 64'hC2CA_FFFF_DFFF_FFFF;
    localparam logic [63:0] SPECIAL_OK = ~(64'h1 << 6'h01 | 64'h1 << 6'h05 | 64'h1 << 6'h0E |
        64'h1 << 6'h15 | 64'h1 << 6'h1C | 64'h1 << 6'h1D | 64'h1 << 6'h1E | 64'h1 << 6'h1F |
        64'h1 << 6'h35 | 64'h1 << 6'h37 | 64'h1 << 6'h39 | 64'h1 << 6'h3D);
    localparam logic [31:0] REGIMM_OK = 32'h030F_5F0F;
    localparam logic [63:0] TLB_OK = 64'h0300_0000_0100_0146;
    localparam logic [63:0] FPUS_OK = 64'h0055_0310_F740_00FF;
    localparam logic [63:0] VU1_OK = 64'h0337_FFFF_FFFF_FFFF;
    localparam logic [127:0] VU2_OK = {64'hF, ~(64'h1 << 6'h2B | 64'h1 << 6'h32 | 64'h1 << 6'h33)};
    localparam logic [63:0] MMI_OK = 64'h0F0F_0000;

    typedef struct packed {
        logic [3:0] group;
        logic [7:0] sel;
        logic       rsvd;
    } t_dec;
endpackage

FILE: rtl/core/r5k_dec_logic.sv
// Combinational classification of one instruction word
module r5k_dec_logic (
    input  logic [31:0]        i_word,
    output r5k_dec_pkg::t_dec  o_dec
);
    import r5k_dec_pkg::*;

    logic [5:0] opc, fn;
    logic [4:0] rs, rt;
    logic [6:0] code;

    assign opc  = i_word[31:26];
    assign rs   = i_word[25:21];
    assign rt   = i_word[20:16];
    assign fn   = i_word[5:0];
    assign code = {i_word[10:6], i_word[1:0]};

    always_comb begin
        o_dec.group = G_MAIN;
        o_dec.sel   = {2'b00, opc};
        o_dec.rsvd  = !MAIN_OK[opc];
        case (opc)
            OP_SPECIAL: begin
                o_dec = '{G_SPECIAL, {2'b00, fn}, !SPECIAL_OK[fn]};
            end
            OP_REGIMM: begin
                o_dec = '{G_REGIMM, {3'b000, rt}, !REGIMM_OK[rt]};
            end
            OP_COP0: begin
                if (rs == FMT_BC) begin
                    o_dec = '{G_BC0, {3'b000, rt}, rt[4:2] != 3'd0};
                end else if (rs == FMT_CO) begin
                    o_dec = '{G_TLB, {2'b00, fn}, !TLB_OK[fn]};
                end else begin
                    o_dec = '{G_COP0MV, {3'b000, rs}, !(rs == 5'd0 || rs == 5'd4)};
                end
            end
            OP_COP1: begin
                if (rs == FMT_BC) begin
                    o_dec = '{G_BC1, {3'b000, rt}, rt[4:2] != 3'd0};
                end else if (rs == FMT_CO) begin
                    o_dec = '{G_FPUS, {2'b00, fn}, !FPUS_OK[fn]};
                end else if (rs == FMT_W) begin
                    o_dec = '{G_FPUW, {2'b00, fn}, fn != FN_CVTS};
                end else begin
                    o_dec = '{G_COP1MV, {3'b000, rs}, !(rs inside {5'd0, 5'd2, 5'd4, 5'd6})};
                end
            end
            OP_COP2: begin
                if (rs[4]) begin
                    if (fn[5:2] == 4'hF) begin
                        o_dec = '{G_VU2, {1'b0, code}, !VU2_OK[code]};
                    end else begin
                        o_dec = '{G_VU1, {2'b00, fn}, !VU1_OK[fn]};
                    end
                end else if (rs == FMT_BC) begin
                    o_dec = '{G_BC2, {3'b000, rt}, rt[4:2] != 3'd0};
                end else begin
                    o_dec = '{G_COP2MV, {3'b000, rs}, !(rs inside {5'd1, 5'd2, 5'd5, 5'd6})};
                end
            end
            OP_COP3: begin
                o_dec = '{G_COP3, {2'b00, OP_COP3}, 1'b0};
            end
            OP_MMI: begin
                o_dec = '{G_MMI, {2'b00, fn}, !MMI_OK[fn]};
            end
            default: begin
                o_dec.rsvd = !MAIN_OK[opc];
            end
        endcase
    end
endmodule

FILE: rtl/core/r5900_instruction_decoder.sv
// Top level: registered R5900 instruction decoder with stream handshake
//  channel | dir | tdata / tuser
//  s_axis  | in  | tdata[31:0] instruction_word
//  m_axis  | out | tdata[79:0] see port comment
// One request per cycle while the result register is free; the result is valid in the cycle after acceptance.
// The result register frees whenever it is empty or being taken.
// Reset (synchronous, active low) empties the result register.
module r5900_instruction_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] instruction_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] op_group, [11:4] op_select, [12] reserved_flag, [17:13] reg_s,
    // [22:18] reg_t, [27:23] reg_d, [32:28] shift_amount, [48:33] immediate16,
    // [74:49] jump_target26, [79:75] zero
    output logic [79:0] m_axis_tdata
);
    import r5k_dec_pkg::*;
    `include "r5900_instruction_decoder_defines.svh"

    t_dec        w_dec;
    logic        r_valid;
    logic [79:0] r_data;

    r5k_dec_logic u_dec (.i_word(s_axis_tdata), .o_dec(w_dec));

    assign s_axis_tready = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_data <= {5'd0, s_axis_tdata[25:0], s_axis_tdata[15:0], s_axis_tdata[10:6],
                       s_axis_tdata[15:11], s_axis_tdata[20:16], s_axis_tdata[25:21],
                       w_dec.rsvd, w_dec.sel, w_dec.group};
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;

    `R5K_ASSERT_NEXT(a_hold, r_valid && !m_axis_tready, r_valid && $stable(r_data), "held result changed")
    `R5K_ASSERT(a_cop3, r_valid && r_data[3:0] == G_COP3 |-> !r_data[12], "cop3 flagged")
    `R5K_ASSERT_NEXT(a_fill, s_axis_tvalid && s_axis_tready, r_valid, "request lost")
endmodule
